>>> rtl/tns_pkg.sv
// ----------------------------------------------------------------------------
// tns_pkg
// Types, constants and codes shared by the text noise sniffer modules.
// ----------------------------------------------------------------------------
package tns_pkg;

  // default sizes of the sampling window
  localparam int SampleMaxDefault = 8192;
  localparam int LineMaxDefault   = 127;

  // field widths
  localparam int SampleLimitW = 14;
  localparam int LineLimitW   = 7;
  localparam int PercentW     = 7;
  localparam int MinLengthW   = 4;
  localparam int CountW       = 7;
  localparam int ByteCountW   = 14;
  localparam int VerdictW     = 2;
  localparam int CfgIdxW      = 3;
  localparam int CfgDataW     = 14;

  // per-line limits
  localparam logic [3:0] LineLenSat  = 4'd8;
  localparam logic [3:0] HostLenMin  = 4'd7;
  localparam logic [1:0] TokenSat    = 2'd3;
  localparam logic [1:0] ShortTokMax = 2'd2;
  localparam int         PercentScale = 100;

  // depth of the queue between front and back
  localparam int QueueDepth = 4;

  // reset values of the configuration registers
  localparam logic [SampleLimitW-1:0] SampleLimitRst   = 14'd8192;
  localparam logic [LineLimitW-1:0]   LineLimitRst     = 7'd100;
  localparam logic [PercentW-1:0]     HostPercentRst   = 7'd15;
  localparam logic [PercentW-1:0]     ShortPercentRst  = 7'd80;
  localparam logic [PercentW-1:0]     LetterPercentRst = 7'd40;
  localparam logic [MinLengthW-1:0]   MinLengthRst     = 4'd4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SAMPLE_LIMIT,
    CFG_LINE_LIMIT,
    CFG_HOST_PERCENT,
    CFG_SHORT_PERCENT,
    CFG_LETTER_PERCENT,
    CFG_MIN_LENGTH
  } cfg_idx_e;

  typedef enum logic [VerdictW-1:0] {
    VERDICT_SKIP = 2'd0,
    VERDICT_CODE = 2'd1,
    VERDICT_KEEP = 2'd2
  } verdict_e;

  // scan of the dotted address at the start of a line
  typedef enum logic [3:0] {
    PH_LEAD,
    PH_RUN0,
    PH_DOT1,
    PH_RUN1,
    PH_DOT2,
    PH_RUN2,
    PH_DOT3,
    PH_DONE,
    PH_FAIL
  } addr_phase_e;

  typedef struct packed {
    logic [SampleLimitW-1:0] sample_limit;
    logic [LineLimitW-1:0]   line_limit;
    logic [PercentW-1:0]     host_percent;
    logic [PercentW-1:0]     short_percent;
    logic [PercentW-1:0]     letter_percent;
    logic [MinLengthW-1:0]   min_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_item_t;

  // classified byte handed from front to back
  typedef struct packed {
    logic       final_byte;
    logic       newline;
    logic       blank;
    logic       digit;
    logic       letter;
    logic       dot;
    logic [3:0] digit_val;
  } cls_t;

  typedef struct packed {
    logic [VerdictW-1:0]   verdict;
    logic [CountW-1:0]     lines_seen;
    logic [CountW-1:0]     host_lines;
    logic [CountW-1:0]     short_lines;
    logic [ByteCountW-1:0] letter_count;
    logic [ByteCountW-1:0] nonspace_count;
  } result_t;

endpackage

>>> rtl/tns_stream_if.sv
// ----------------------------------------------------------------------------
// tns_stream_if
// Valid/ready channel carrying one payload of type T per transaction.
// ----------------------------------------------------------------------------
interface tns_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

>>> rtl/tns_front.sv
// ----------------------------------------------------------------------------
// tns_front
// Accepts text bytes and registers their character class for the back end.
// ----------------------------------------------------------------------------
module tns_front (
  input  logic        clk_i,
  input  logic        rst_ni,
  tns_stream_if.sink   in_i,
  tns_stream_if.source cls_o
);

  import tns_pkg::*;

  logic valid_q, valid_d;
  cls_t cls_q, cls_c;
  logic take;
  logic [7:0] c;

  assign c = in_i.data.text_byte;

  always_comb begin
    cls_c            = '0;
    cls_c.final_byte = in_i.data.final_byte;
    cls_c.newline    = (c == 8'h0A);
    cls_c.blank      = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    cls_c.digit      = (c >= 8'h30 && c <= 8'h39);
    cls_c.letter     = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    cls_c.dot        = (c == 8'h2E);
    cls_c.digit_val  = c[3:0];
  end

  assign in_i.ready  = !valid_q || cls_o.ready;
  assign take        = in_i.valid && in_i.ready;
  assign cls_o.valid = valid_q;
  assign cls_o.data  = cls_q;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (cls_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cls_q <= cls_c;
    end
  end

endmodule

>>> rtl/tns_queue.sv
// ----------------------------------------------------------------------------
// tns_queue
// Short first-in first-out queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
module tns_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  tns_stream_if.sink   in_i,
  tns_stream_if.source out_o
);

  import tns_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);

  cls_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            push, pop;

  assign in_i.ready  = (count_q != (PtrW + 1)'(QueueDepth));
  assign out_o.valid = (count_q != '0);
  assign out_o.data  = mem_q[rd_ptr_q];
  assign push        = in_i.valid && in_i.ready;
  assign pop         = out_o.valid && out_o.ready;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_i.data;
    end
  end

endmodule

>>> rtl/tns_back.sv
// ----------------------------------------------------------------------------
// tns_back
// Per-text counters, line and address scan, and the verdict pipeline.
// ----------------------------------------------------------------------------
module tns_back #(
  parameter int SAMPLE_MAX = tns_pkg::SampleMaxDefault,
  parameter int LINE_MAX   = tns_pkg::LineMaxDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  tns_pkg::cfg_t cfg_i,
  tns_stream_if.sink     in_i,
  tns_stream_if.source   out_o
);

  import tns_pkg::*;

  localparam int BW  = $clog2(SAMPLE_MAX + 1);
  localparam int LW  = $clog2(LINE_MAX + 1);
  localparam int CW  = (BW > SampleLimitW) ? BW : SampleLimitW;
  localparam int LCW = (LW > LineLimitW) ? LW : LineLimitW;
  localparam int PW  = LW + PercentW;
  localparam int QW  = BW + PercentW;
  localparam logic [BW-1:0] SampleMaxB = BW'(SAMPLE_MAX);
  localparam logic [LW-1:0] LineMaxL   = LW'(LINE_MAX);

  // per-text state
  logic [BW-1:0] bytes_q, bytes_d, bytes_u;
  logic [LW-1:0] lines_q, lines_d, lines_u;
  logic [LW-1:0] host_q, host_d, host_u;
  logic [LW-1:0] short_q, short_d, short_u;
  logic [BW-1:0] letters_q, letters_d, letters_u;
  logic [BW-1:0] nons_q, nons_d, nons_u;
  logic          open_q, open_d, open_u;
  logic [3:0]    len_q, len_d, len_u, b_len, len_n;
  logic [1:0]    tok_q, tok_d, tok_u, b_tok, tok_n;
  logic          intok_q, intok_d, intok_u, b_intok, intok_n;
  addr_phase_e   phase_q, phase_d, phase_u, b_phase, phase_n;
  logic [8:0]    fv_q, fv_d, fv_u, b_fv, fv_n;
  logic          ok_q, ok_d, ok_u, b_ok, ok_n;
  logic [11:0]   fv_mul;

  cls_t          cls;
  logic          take, fin, win, nl, step, do_end;
  logic [CW-1:0] limit_c;

  // verdict pipeline
  logic          s1_valid_q, s1_valid_d;
  logic [BW-1:0] s1_bytes_q, s1_letters_q, s1_nons_q;
  logic [LW-1:0] s1_lines_q, s1_host_q, s1_short_q;
  logic          s1_free, out_adv;
  logic          out_valid_q, out_valid_d;
  result_t       out_q, out_c;
  logic          short_text, host_bad, short_bad, letter_low;

  assign cls  = in_i.data;
  assign fin  = cls.final_byte;
  assign nl   = cls.newline;

  assign out_adv    = !out_valid_q || out_o.ready;
  assign s1_free    = !s1_valid_q || out_adv;
  assign in_i.ready = !fin || s1_free;
  assign take       = in_i.valid && in_i.ready;

  assign limit_c = (CW'(cfg_i.sample_limit) < CW'(SAMPLE_MAX)) ?
                   CW'(cfg_i.sample_limit) : CW'(SAMPLE_MAX);
  assign win  = (CW'(bytes_q) < limit_c) && (LCW'(lines_q) < LCW'(cfg_i.line_limit));
  assign step = win && !nl;

  // a closed line restarts its per-line state on its first byte
  assign b_len   = open_q ? len_q : '0;
  assign b_tok   = open_q ? tok_q : '0;
  assign b_intok = open_q && intok_q;
  assign b_phase = open_q ? phase_q : PH_LEAD;
  assign b_fv    = open_q ? fv_q : '0;
  assign b_ok    = open_q && ok_q;

  always_comb begin
    len_n   = (b_len < LineLenSat) ? b_len + 4'd1 : b_len;
    intok_n = !cls.blank;
    tok_n   = b_tok;
    if (!cls.blank && !b_intok && b_tok != TokenSat) begin
      tok_n = b_tok + 2'd1;
    end
  end

  // address scan: next phase
  always_comb begin
    phase_n = b_phase;
    case (b_phase)
      PH_LEAD: begin
        if (cls.digit) begin
          phase_n = PH_RUN0;
        end else if (!cls.blank) begin
          phase_n = PH_FAIL;
        end
      end
      PH_RUN0, PH_RUN1, PH_RUN2: begin
        if (cls.dot) begin
          if (b_phase != PH_RUN2 && b_fv[8]) begin
            phase_n = PH_FAIL;
          end else if (b_phase == PH_RUN0) begin
            phase_n = PH_DOT1;
          end else if (b_phase == PH_RUN1) begin
            phase_n = PH_DOT2;
          end else begin
            phase_n = PH_DOT3;
          end
        end else if (!cls.digit) begin
          phase_n = PH_FAIL;
        end
      end
      PH_DOT1: phase_n = cls.digit ? PH_RUN1 : PH_FAIL;
      PH_DOT2: phase_n = cls.digit ? PH_RUN2 : PH_FAIL;
      PH_DOT3: phase_n = cls.digit ? PH_DONE : PH_FAIL;
      PH_DONE: phase_n = PH_DONE;
      PH_FAIL: phase_n = PH_FAIL;
      default: phase_n = PH_FAIL;
    endcase
  end

  // address scan: run value and match flag
  assign fv_mul = 12'(b_fv) * 12'd10 + 12'(cls.digit_val);

  always_comb begin
    fv_n = b_fv;
    ok_n = b_ok;
    case (b_phase)
      PH_LEAD, PH_DOT1, PH_DOT2: begin
        if (cls.digit) begin
          fv_n = 9'(cls.digit_val);
        end
      end
      PH_RUN0, PH_RUN1, PH_RUN2: begin
        if (cls.digit) begin
          fv_n = (fv_mul > 12'd256) ? 9'd256 : fv_mul[8:0];
        end else if (cls.dot) begin
          fv_n = '0;
        end
      end
      PH_DOT3: begin
        if (cls.digit) begin
          ok_n = 1'b1;
        end
      end
      default: begin
        fv_n = b_fv;
      end
    endcase
  end

  // state after this byte, before the clear at the end of a text
  always_comb begin
    len_u   = win ? (nl ? b_len : len_n) : len_q;
    tok_u   = win ? (nl ? b_tok : tok_n) : tok_q;
    intok_u = win ? (nl ? b_intok : intok_n) : intok_q;
    phase_u = win ? (nl ? b_phase : phase_n) : phase_q;
    fv_u    = win ? (nl ? b_fv : fv_n) : fv_q;
    ok_u    = win ? (nl ? b_ok : ok_n) : ok_q;
    open_u  = win ? !nl : open_q;

    letters_u = letters_q;
    if (step && cls.letter && letters_q < SampleMaxB) begin
      letters_u = letters_q + 1'b1;
    end
    nons_u = nons_q;
    if (step && !cls.blank && nons_q < SampleMaxB) begin
      nons_u = nons_q + 1'b1;
    end
    bytes_u = (bytes_q < SampleMaxB) ? bytes_q + 1'b1 : bytes_q;

    // a line closes on a newline, or when the text ends with it open
    do_end  = (win && nl) || (fin && open_u);
    lines_u = lines_q;
    short_u = short_q;
    host_u  = host_q;
    if (do_end) begin
      if (lines_q < LineMaxL) begin
        lines_u = lines_q + 1'b1;
      end
      if (tok_u <= ShortTokMax && short_q < LineMaxL) begin
        short_u = short_q + 1'b1;
      end
      if (ok_u && len_u > HostLenMin && host_q < LineMaxL) begin
        host_u = host_q + 1'b1;
      end
    end
  end

  always_comb begin
    bytes_d   = bytes_q;
    lines_d   = lines_q;
    host_d    = host_q;
    short_d   = short_q;
    letters_d = letters_q;
    nons_d    = nons_q;
    open_d    = open_q;
    len_d     = len_q;
    tok_d     = tok_q;
    intok_d   = intok_q;
    phase_d   = phase_q;
    fv_d      = fv_q;
    ok_d      = ok_q;
    if (take) begin
      if (fin) begin
        bytes_d   = '0;
        lines_d   = '0;
        host_d    = '0;
        short_d   = '0;
        letters_d = '0;
        nons_d    = '0;
        open_d    = 1'b0;
        len_d     = '0;
        tok_d     = '0;
        intok_d   = 1'b0;
        phase_d   = PH_LEAD;
        fv_d      = '0;
        ok_d      = 1'b0;
      end else begin
        bytes_d   = bytes_u;
        lines_d   = lines_u;
        host_d    = host_u;
        short_d   = short_u;
        letters_d = letters_u;
        nons_d    = nons_u;
        open_d    = open_u;
        len_d     = len_u;
        tok_d     = tok_u;
        intok_d   = intok_u;
        phase_d   = phase_u;
        fv_d      = fv_u;
        ok_d      = ok_u;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_q   <= '0;
      lines_q   <= '0;
      host_q    <= '0;
      short_q   <= '0;
      letters_q <= '0;
      nons_q    <= '0;
      open_q    <= 1'b0;
      len_q     <= '0;
      tok_q     <= '0;
      intok_q   <= 1'b0;
      phase_q   <= PH_LEAD;
      fv_q      <= '0;
      ok_q      <= 1'b0;
    end else begin
      bytes_q   <= bytes_d;
      lines_q   <= lines_d;
      host_q    <= host_d;
      short_q   <= short_d;
      letters_q <= letters_d;
      nons_q    <= nons_d;
      open_q    <= open_d;
      len_q     <= len_d;
      tok_q     <= tok_d;
      intok_q   <= intok_d;
      phase_q   <= phase_d;
      fv_q      <= fv_d;
      ok_q      <= ok_d;
    end
  end

  // snapshot of the finished text
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (take && fin) begin
      s1_valid_d = 1'b1;
    end else if (out_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i) begin
    if (take && fin) begin
      s1_bytes_q   <= bytes_u;
      s1_lines_q   <= lines_u;
      s1_host_q    <= host_u;
      s1_short_q   <= short_u;
      s1_letters_q <= letters_u;
      s1_nons_q    <= nons_u;
    end
  end

  // ratio tests against the percent registers
  assign short_text = CW'(s1_bytes_q) < CW'(cfg_i.min_length);
  assign host_bad   = PW'(s1_host_q) * PW'(PercentScale) >
                      PW'(s1_lines_q) * PW'(cfg_i.host_percent);
  assign short_bad  = PW'(s1_short_q) * PW'(PercentScale) >
                      PW'(s1_lines_q) * PW'(cfg_i.short_percent);
  assign letter_low = QW'(s1_letters_q) * QW'(PercentScale) <
                      QW'(s1_nons_q) * QW'(cfg_i.letter_percent);

  always_comb begin
    out_c                = '0;
    out_c.lines_seen     = CountW'(s1_lines_q);
    out_c.host_lines     = CountW'(s1_host_q);
    out_c.short_lines    = CountW'(s1_short_q);
    out_c.letter_count   = ByteCountW'(s1_letters_q);
    out_c.nonspace_count = ByteCountW'(s1_nons_q);
    if (short_text || s1_lines_q == '0 || host_bad || short_bad) begin
      out_c.verdict = VERDICT_SKIP;
    end else if (s1_nons_q == '0) begin
      out_c.verdict = (cfg_i.letter_percent != '0) ? VERDICT_CODE : VERDICT_KEEP;
    end else begin
      out_c.verdict = letter_low ? VERDICT_CODE : VERDICT_KEEP;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_adv && s1_valid_q) begin
      out_q <= out_c;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

`ifndef ASSERT_OFF
  a_host_le_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    host_q <= lines_q)
    else $error("host line count above line count");

  a_short_le_lines: assert property (@(posedge clk_i) disable iff (!rst_ni)
    short_q <= lines_q)
    else $error("short line count above line count");

  a_clear_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && fin |=> bytes_q == '0 && !open_q && lines_q == '0)
    else $error("text state not cleared after last byte");

  a_snapshot_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_adv |=> s1_valid_q && $stable(s1_lines_q))
    else $error("pending verdict snapshot lost under back-pressure");
`endif

endmodule

>>> rtl/text_noise_sniffer_top.sv
// ----------------------------------------------------------------------------
// text_noise_sniffer_top
// Streams a text byte by byte and judges it skip, code or keep.
// ----------------------------------------------------------------------------
// Takes one byte per clock cycle, back to back across texts, save that the
// back end holds a last byte only while a verdict is pending; the figure is
// set by the counter and address-scan update in the back end. A byte passes
// an input register, a four-entry queue and the state update; the verdict
// for a text passes the snapshot and output registers after its last byte
// is taken, when the output side is ready. The configuration registers must
// be written through the plain write port while the block is idle, which
// the block does not enforce; there is no clearing pass after reset.
module text_noise_sniffer_top #(
  parameter int SAMPLE_MAX = tns_pkg::SampleMaxDefault,
  parameter int LINE_MAX   = tns_pkg::LineMaxDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tns_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [tns_pkg::CfgDataW-1:0]  cfg_data_i,
  tns_stream_if.sink                    in_i,
  tns_stream_if.source                  out_o
);

  import tns_pkg::*;

  cfg_t cfg_q, cfg_d;

  tns_stream_if #(.T(cls_t)) front_q ();
  tns_stream_if #(.T(cls_t)) queue_b ();

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SAMPLE_LIMIT:   cfg_d.sample_limit   = cfg_data_i[SampleLimitW-1:0];
        CFG_LINE_LIMIT:     cfg_d.line_limit     = cfg_data_i[LineLimitW-1:0];
        CFG_HOST_PERCENT:   cfg_d.host_percent   = cfg_data_i[PercentW-1:0];
        CFG_SHORT_PERCENT:  cfg_d.short_percent  = cfg_data_i[PercentW-1:0];
        CFG_LETTER_PERCENT: cfg_d.letter_percent = cfg_data_i[PercentW-1:0];
        CFG_MIN_LENGTH:     cfg_d.min_length     = cfg_data_i[MinLengthW-1:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_limit   <= SampleLimitRst;
      cfg_q.line_limit     <= LineLimitRst;
      cfg_q.host_percent   <= HostPercentRst;
      cfg_q.short_percent  <= ShortPercentRst;
      cfg_q.letter_percent <= LetterPercentRst;
      cfg_q.min_length     <= MinLengthRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  tns_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cls_o  (front_q)
  );

  tns_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (front_q),
    .out_o  (queue_b)
  );

  tns_back #(
    .SAMPLE_MAX (SAMPLE_MAX),
    .LINE_MAX   (LINE_MAX)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .in_i   (queue_b),
    .out_o  (out_o)
  );

endmodule

>>> sim/text_noise_sniffer_checker.sv
// ----------------------------------------------------------------------------
// text_noise_sniffer_checker
// Watches the byte and verdict channels of the text noise sniffer, keeps its
// own copy of the registers and the per-text counters, predicts the verdict
// of every text and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module text_noise_sniffer_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tns_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [tns_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  tns_pkg::in_item_t            in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  tns_pkg::result_t             out_data_i,
  output int                           pending_o,
  output int                           fails_o,
  output int                           checked_o
);

  import tns_pkg::*;

  localparam int         SampleMax  = SampleMaxDefault;
  localparam int         LineMax    = LineMaxDefault;
  localparam int         MaxReports = 10;
  localparam logic [7:0] ChNl       = 8'h0A;
  localparam logic [7:0] ChDot      = 8'h2E;
  localparam logic [8:0] RunSat     = 9'd256;

  typedef struct packed {
    logic [ByteCountW-1:0] taken;
    logic [CountW-1:0]     lines;
    logic [CountW-1:0]     hosts;
    logic [CountW-1:0]     shorts;
    logic [ByteCountW-1:0] alpha;
    logic [ByteCountW-1:0] ink;
    logic                  open;
    logic [3:0]            len;
    logic [1:0]            toks;
    logic                  in_tok;
    addr_phase_e           phase;
    logic [8:0]            val;
    logic                  addr_ok;
  } text_stats_t;

  cfg_t        regs;
  text_stats_t st;
  result_t     verdict_q[$];

  function automatic bit blank_char(logic [7:0] c);
    return c == 8'h20 || c inside {[8'h09:8'h0D]};
  endfunction

  function automatic bit digit_char(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic bit letter_char(logic [7:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  endfunction

  task automatic close_line();
    if (st.lines < LineMax) st.lines++;
    if (st.toks <= ShortTokMax && st.shorts < LineMax) st.shorts++;
    if (st.addr_ok && st.len > HostLenMin && st.hosts < LineMax) st.hosts++;
    st.open = 1'b0;
  endtask

  // dotted address at the start of a line: four digit runs, first two below 256
  task automatic scan_address(logic [7:0] c);
    int unsigned v;
    case (st.phase)
      PH_LEAD: begin
        if (digit_char(c)) begin
          st.phase = PH_RUN0;
          st.val   = 9'(c[3:0]);
        end else if (!blank_char(c)) begin
          st.phase = PH_FAIL;
        end
      end
      PH_DOT1, PH_DOT2, PH_DOT3: begin
        if (!digit_char(c)) begin
          st.phase = PH_FAIL;
        end else if (st.phase == PH_DOT3) begin
          st.addr_ok = 1'b1;
          st.phase   = PH_DONE;
        end else begin
          st.phase = (st.phase == PH_DOT1) ? PH_RUN1 : PH_RUN2;
          st.val   = 9'(c[3:0]);
        end
      end
      PH_RUN0, PH_RUN1, PH_RUN2: begin
        if (digit_char(c)) begin
          v      = st.val * 10 + c[3:0];
          st.val = (v > RunSat) ? RunSat : 9'(v);
        end else if (c == ChDot) begin
          if (st.phase != PH_RUN2 && st.val >= RunSat) begin
            st.phase = PH_FAIL;
          end else begin
            case (st.phase)
              PH_RUN0: st.phase = PH_DOT1;
              PH_RUN1: st.phase = PH_DOT2;
              default: st.phase = PH_DOT3;
            endcase
            st.val = '0;
          end
        end else begin
          st.phase = PH_FAIL;
        end
      end
      default: ;
    endcase
  endtask

  function automatic verdict_e judge();
    int unsigned n;
    n = st.lines;
    if (st.taken < regs.min_length || n == 0) return VERDICT_SKIP;
    if (st.hosts * PercentScale > n * regs.host_percent) return VERDICT_SKIP;
    if (st.shorts * PercentScale > n * regs.short_percent) return VERDICT_SKIP;
    if (st.ink == 0) return (regs.letter_percent != 0) ? VERDICT_CODE : VERDICT_KEEP;
    if (32'(st.alpha) * PercentScale < 32'(st.ink) * regs.letter_percent) begin
      return VERDICT_CODE;
    end
    return VERDICT_KEEP;
  endfunction

  task automatic sniff_byte(in_item_t it);
    logic [7:0]  c;
    int unsigned window;
    result_t     want;
    c      = it.text_byte;
    window = (regs.sample_limit < SampleMax) ? regs.sample_limit : SampleMax;
    if (st.taken < window && st.lines < regs.line_limit) begin
      if (!st.open) begin
        st.open    = 1'b1;
        st.len     = '0;
        st.toks    = '0;
        st.in_tok  = 1'b0;
        st.phase   = PH_LEAD;
        st.val     = '0;
        st.addr_ok = 1'b0;
      end
      if (c == ChNl) begin
        close_line();
      end else begin
        if (st.len < LineLenSat) st.len++;
        if (blank_char(c)) begin
          st.in_tok = 1'b0;
        end else begin
          if (!st.in_tok) begin
            st.in_tok = 1'b1;
            if (st.toks < TokenSat) st.toks++;
          end
          if (st.ink < SampleMax) st.ink++;
        end
        if (letter_char(c) && st.alpha < SampleMax) st.alpha++;
        scan_address(c);
      end
    end
    if (st.taken < SampleMax) st.taken++;

    if (it.final_byte) begin
      // a line still open at the end of the text counts
      if (st.open) close_line();
      want.verdict        = judge();
      want.lines_seen     = st.lines;
      want.host_lines     = st.hosts;
      want.short_lines    = st.shorts;
      want.letter_count   = st.alpha;
      want.nonspace_count = st.ink;
      verdict_q.push_back(want);
      st = '0;
    end
  endtask

  task automatic check_result(result_t got);
    result_t want;
    if (verdict_q.size() == 0) begin
      fails_o++;
      if (fails_o <= MaxReports) begin
        $display("%0t: verdict transaction with nothing outstanding: verdict %0d lines %0d",
                 $time, got.verdict, got.lines_seen);
      end
      return;
    end
    want = verdict_q.pop_front();
    checked_o++;
    if (got.verdict !== want.verdict || got.lines_seen !== want.lines_seen ||
        got.host_lines !== want.host_lines || got.short_lines !== want.short_lines ||
        got.letter_count !== want.letter_count ||
        got.nonspace_count !== want.nonspace_count) begin
      fails_o++;
      if (fails_o <= MaxReports) begin
        $display("%0t: mismatch exp verdict %0d lines %0d host %0d short %0d letters %0d ink %0d",
                 $time, want.verdict, want.lines_seen, want.host_lines, want.short_lines,
                 want.letter_count, want.nonspace_count);
        $display("%0t:          got verdict %0d lines %0d host %0d short %0d letters %0d ink %0d",
                 $time, got.verdict, got.lines_seen, got.host_lines, got.short_lines,
                 got.letter_count, got.nonspace_count);
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.sample_limit   = SampleLimitRst;
      regs.line_limit     = LineLimitRst;
      regs.host_percent   = HostPercentRst;
      regs.short_percent  = ShortPercentRst;
      regs.letter_percent = LetterPercentRst;
      regs.min_length     = MinLengthRst;
      st                  = '0;
      verdict_q.delete();
      pending_o           = 0;
      fails_o             = 0;
      checked_o           = 0;
    end else begin
      if (out_valid_i && out_ready_i) check_result(out_data_i);
      if (in_valid_i && in_ready_i) sniff_byte(in_data_i);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_SAMPLE_LIMIT:   regs.sample_limit   = cfg_data_i[SampleLimitW-1:0];
          CFG_LINE_LIMIT:     regs.line_limit     = cfg_data_i[LineLimitW-1:0];
          CFG_HOST_PERCENT:   regs.host_percent   = cfg_data_i[PercentW-1:0];
          CFG_SHORT_PERCENT:  regs.short_percent  = cfg_data_i[PercentW-1:0];
          CFG_LETTER_PERCENT: regs.letter_percent = cfg_data_i[PercentW-1:0];
          CFG_MIN_LENGTH:     regs.min_length     = cfg_data_i[MinLengthW-1:0];
          default: ;
        endcase
      end
      pending_o = verdict_q.size();
    end
  end

endmodule

>>> sim/text_noise_sniffer_top_test.sv
// ----------------------------------------------------------------------------
// text_noise_sniffer_top_test
// Feeds texts into the text noise sniffer under a series of register
// settings: a few hand-made texts, one text that fills the whole sample, and
// random mixes of address, prose, code, noise and empty lines, with random
// gaps on the byte side and random stalls on the verdict side. The checker
// beside the block predicts and compares every verdict.
// ----------------------------------------------------------------------------
module text_noise_sniffer_top_test;
  import tns_pkg::*;

  localparam int         NumRegs    = 6;
  localparam int         NumPhases  = 10;
  localparam int         LongPhase  = 4;
  localparam int         LongSample = 160;
  localparam int         PhaseBytes = 70;
  localparam int         SettleCyc  = 12;
  localparam int         StallLimit = 4000;
  localparam logic [7:0] ChNl       = 8'h0A;
  localparam logic [7:0] ChDot      = 8'h2E;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  cfg_idx_e            cfg_idx;
  logic [CfgDataW-1:0] cfg_data;

  tns_stream_if #(.T(in_item_t)) in_if ();
  tns_stream_if #(.T(result_t))  out_if ();

  int pending, fails, checked;
  int texts_sent, bytes_sent, idle_cycles;
  int rdy_left;
  int rdy_pick;

  logic [7:0]          text_q[$];
  logic [CfgDataW-1:0] reg_val [NumRegs];

  text_noise_sniffer_top DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  text_noise_sniffer_checker checker_i (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_if.valid),
    .in_ready_i  (in_if.ready),
    .in_data_i   (in_if.data),
    .out_valid_i (out_if.valid),
    .out_ready_i (out_if.ready),
    .out_data_i  (out_if.data),
    .pending_o   (pending),
    .fails_o     (fails),
    .checked_o   (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // verdict side: long ready runs, short stalls, now and then a long stall
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_pick = $urandom_range(0, 99);
      if (rdy_pick < 25) begin
        out_if.ready <= 1'b1;
        rdy_left = $urandom_range(20, 200);
      end else if (rdy_pick < 60) begin
        out_if.ready <= 1'b1;
        rdy_left = $urandom_range(1, 4);
      end else if (rdy_pick < 92) begin
        out_if.ready <= 1'b0;
        rdy_left = $urandom_range(1, 3);
      end else begin
        out_if.ready <= 1'b0;
        rdy_left = $urandom_range(10, 50);
      end
    end else begin
      rdy_left--;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("timeout: no transaction for %0d cycles, %0d verdicts outstanding",
                 idle_cycles, pending);
        $display("[text_noise_sniffer_top] ERROR");
        $finish;
      end
    end
  end

  function automatic void add_str(string s);
    foreach (s[i]) text_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 5))
      0:       return 8'h09;
      1:       return 8'h0B;
      2:       return 8'h0C;
      3:       return 8'h0D;
      default: return 8'h20;
    endcase
  endfunction

  function automatic logic [7:0] letter_byte();
    return $urandom_range(0, 1) ? 8'($urandom_range(8'h41, 8'h5A))
                                : 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  function automatic void add_word();
    repeat ($urandom_range(1, 7)) text_q.push_back(letter_byte());
  endfunction

  task automatic make_text();
    int    n_lines, kind, v;
    string code_chars, bad_chars;
    code_chars = "{}();=+-*/<>[]_#.,:0123456789abcxyzXYZ \"";
    bad_chars  = "+- \t";
    text_q.delete();
    if ($urandom_range(0, 11) == 0) begin
      // tiny text, tests the minimum length
      repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(1, 255)));
      return;
    end
    n_lines = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 5);
    for (int ln = 0; ln < n_lines; ln++) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        // dotted address line, occasionally malformed
        repeat ($urandom_range(0, 2)) text_q.push_back(blank_byte());
        for (int f = 0; f < 4; f++) begin
          if (f > 0) text_q.push_back(ChDot);
          if ($urandom_range(0, 15) == 0) text_q.push_back(bad_chars[$urandom_range(0, 3)]);
          case ($urandom_range(0, 4))
            0:       v = 0;
            1:       v = 255;
            2:       v = 256;
            3:       v = $urandom_range(0, 9);
            default: v = $urandom_range(0, 999);
          endcase
          if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) add_str("0");
          if ($urandom_range(0, 19) != 0) add_str($sformatf("%0d", v));
        end
        repeat ($urandom_range(0, 3)) begin
          text_q.push_back(blank_byte());
          add_word();
        end
      end else if (kind < 65) begin
        repeat ($urandom_range(0, 5)) begin
          add_word();
          repeat ($urandom_range(1, 2)) text_q.push_back(blank_byte());
        end
      end else if (kind < 80) begin
        repeat ($urandom_range(1, 12)) begin
          text_q.push_back(code_chars[$urandom_range(0, code_chars.len() - 1)]);
        end
      end else if (kind < 90) begin
        repeat ($urandom_range(0, 10)) text_q.push_back(8'($urandom_range(1, 255)));
      end
      // remaining kinds give an empty line
      if (ln < n_lines - 1 || $urandom_range(0, 1)) text_q.push_back(ChNl);
    end
    if (text_q.size() == 0) text_q.push_back(ChNl);
  endtask

  task automatic send_byte(in_item_t it, bit burst);
    int gap, pick;
    gap = 0;
    if (!burst) begin
      pick = $urandom_range(0, 99);
      if (pick >= 97)      gap = $urandom_range(20, 60);
      else if (pick >= 85) gap = $urandom_range(4, 12);
      else if (pick >= 55) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_text(bit burst);
    in_item_t it;
    foreach (text_q[i]) begin
      it.text_byte  = text_q[i];
      it.final_byte = (i == text_q.size() - 1);
      send_byte(it, burst);
    end
    texts_sent++;
  endtask

  // hold the byte side until every verdict is back
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_regs();
    cfg_idx_e r;
    r = r.first();
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= r;
      cfg_data <= reg_val[i];
      @(posedge clk);
      r = r.next();
    end
    cfg_we <= 1'b0;
  endtask

  task automatic pick_regs(int phase);
    logic [CfgDataW-1:0] hi;
    case (phase)
      1: reg_val = '{14'd16383, 14'd127, 14'd100, 14'd100, 14'd0, 14'd0};
      2: reg_val = '{14'd1, 14'd1, 14'd0, 14'd0, 14'd100, 14'd15};
      // zero limits, upper data bits set on every narrow register
      3: reg_val = '{14'd0, 14'h3F80, 14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF};
      LongPhase: reg_val = '{14'(LongSample), 14'd127, 14'd15, 14'd80, 14'd100, 14'd4};
      default: begin
        case ($urandom_range(0, 3))
          0:       reg_val[CFG_SAMPLE_LIMIT] = 14'($urandom_range(1, 20));
          1:       reg_val[CFG_SAMPLE_LIMIT] = 14'($urandom_range(21, 200));
          2:       reg_val[CFG_SAMPLE_LIMIT] = 14'($urandom_range(8000, 16383));
          default: reg_val[CFG_SAMPLE_LIMIT] = 14'($urandom);
        endcase
        hi = ($urandom_range(0, 2) == 0) ? 14'($urandom) : '0;
        reg_val[CFG_LINE_LIMIT] = {hi[13:7], 7'($urandom_range(0, 1) ?
                                   $urandom_range(1, 8) : $urandom_range(1, 127))};
        hi = ($urandom_range(0, 2) == 0) ? 14'($urandom) : '0;
        reg_val[CFG_HOST_PERCENT] = {hi[13:7], 7'($urandom_range(0, 100))};
        hi = ($urandom_range(0, 2) == 0) ? 14'($urandom) : '0;
        reg_val[CFG_SHORT_PERCENT] = {hi[13:7], 7'($urandom_range(0, 100))};
        hi = ($urandom_range(0, 2) == 0) ? 14'($urandom) : '0;
        reg_val[CFG_LETTER_PERCENT] = {hi[13:7], 7'($urandom_range(0, 100))};
        hi = ($urandom_range(0, 2) == 0) ? 14'($urandom) : '0;
        reg_val[CFG_MIN_LENGTH] = {hi[13:4], 4'($urandom_range(0, 15))};
      end
    endcase
  endtask

  initial begin
    int phase_start;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_SAMPLE_LIMIT;
    cfg_data     = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    rdy_left     = 0;
    idle_cycles  = 0;
    texts_sent   = 0;
    bytes_sent   = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase > 0) begin
        drain();
        repeat (SettleCyc) @(posedge clk);
        pick_regs(phase);
        write_regs();
      end
      if (phase == 0) begin
        // one letter: below the minimum length
        text_q.delete();
        add_str("Z");
        send_text(1'b0);
        // address with leading zero, line of exactly 9 bytes, high byte at the end
        text_q.delete();
        add_str("01.2.3.4");
        text_q.push_back(8'hFF);
        send_text(1'b0);
        // whitespace only, with an empty-looking first line
        text_q = '{8'h20, 8'h09, 8'h0B, ChNl, 8'h0D, 8'h0C};
        send_text(1'b0);
        // leading blank, run of 255, last byte is the newline
        text_q.delete();
        add_str(" 255.0.0.1 q\n");
        send_text(1'b0);
      end
      if (phase == LongPhase) begin
        // one line of letters that runs past the whole sample
        text_q.delete();
        repeat (LongSample + 8) text_q.push_back(letter_byte());
        send_text(1'b1);
      end
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseBytes) begin
        make_text();
        send_text($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 9) == 0) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("run covered %0d texts, %0d bytes, %0d register settings, %0d verdicts compared",
             texts_sent, bytes_sent, NumPhases, checked);
    if (fails == 0 && pending == 0) begin
      $display("[text_noise_sniffer_top] OK");
    end else begin
      $display("%0d mismatches, %0d verdicts never returned", fails, pending);
      $display("[text_noise_sniffer_top] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/tns_pkg.sv
rtl/tns_stream_if.sv
rtl/tns_front.sv
rtl/tns_queue.sv
rtl/tns_back.sv
rtl/text_noise_sniffer_top.sv
sim/text_noise_sniffer_checker.sv
sim/text_noise_sniffer_top_test.sv
